// ===== hdl/mtep_pkg.sv =====
// Shared types, constants and helpers of the MIDI track event parser.
package mtep_pkg;

  localparam int TICK_BITS = 40;
  localparam int COL_BITS  = 5;
  localparam int ROW_BITS  = 6;
  localparam int SLOT_BITS = ROW_BITS + COL_BITS;
  localparam int ROWS      = 1 << ROW_BITS;
  localparam int COLS      = 1 << COL_BITS;
  localparam int SLOTS     = 1 << SLOT_BITS;
  localparam int INFO_W    = TICK_BITS + 7;

  typedef logic [TICK_BITS-1:0] tick_t;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_NEW   = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;

  localparam logic [3:0] K_NOTE      = 4'd0;
  localparam logic [3:0] K_CC        = 4'd1;
  localparam logic [3:0] K_BEND      = 4'd2;
  localparam logic [3:0] K_PRESSURE  = 4'd3;
  localparam logic [3:0] K_PROGRAM   = 4'd4;
  localparam logic [3:0] K_FIRST_CH  = 4'd5;
  localparam logic [3:0] K_PREFIX    = 4'd6;
  localparam logic [3:0] K_TEMPO     = 4'd7;
  localparam logic [3:0] K_TIMESIG   = 4'd8;
  localparam logic [3:0] K_END       = 4'd9;
  localparam logic [3:0] K_MALFORMED = 4'd10;
  localparam logic [3:0] K_DRAIN_END = 4'd11;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [3:0]  channel;
    logic [6:0]  key;
    logic [13:0] value;
    tick_t       tick;
    tick_t       length_ticks;
    logic        short_note;
    logic [23:0] tempo_us;
    logic [2:0]  den_log2;
    logic        last;
  } result_t;

  typedef enum logic [1:0] {
    NA_NONE = 2'd0,
    NA_ON   = 2'd1,
    NA_OFF  = 2'd2
  } note_act_t;

  typedef struct packed {
    logic                 drain;
    logic                 clear;
    note_act_t            act;
    logic [SLOT_BITS-1:0] idx;
    tick_t                tick;
    logic [6:0]           vel;
    logic [1:0]           nres;
    result_t [1:0]        res;
  } stage_t;

  typedef struct packed {
    logic [1:0]    n;
    result_t [1:0] res;
  } push_t;

  function automatic result_t mk_simple(logic [3:0] kind, logic [3:0] ch, logic [6:0] key,
                                        logic [13:0] val, tick_t tick);
    result_t r;
    r            = '0;
    r.event_kind = kind;
    r.channel    = ch;
    r.key        = key;
    r.value      = val;
    r.tick       = tick;
    return r;
  endfunction

endpackage

// ===== hdl/mtep_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module mtep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mtep_parser.sv =====
// Byte-level track parser: delta times, status, meta and sysex handling.
module mtep_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  mtep_pkg::item_t        item,
  output mtep_pkg::stage_t       stage
);

  localparam int TICK_BITS_W = mtep_pkg::TICK_BITS;

  typedef enum logic [8:0] {
    PH_DELTA     = 9'b000000001,
    PH_STATUS    = 9'b000000010,
    PH_META_TYPE = 9'b000000100,
    PH_META_LEN  = 9'b000001000,
    PH_META_DATA = 9'b000010000,
    PH_SYSEX_LEN = 9'b000100000,
    PH_SKIP      = 9'b001000000,
    PH_DATA1     = 9'b010000000,
    PH_DATA2     = 9'b100000000
  } phase_t;

  phase_t          phase, phase_next, p_phase;
  mtep_pkg::tick_t tick, tick_next, p_tick;
  logic [7:0]      rs, rs_next, p_rs;
  logic [27:0]     acc, acc_next, p_acc;
  logic [2:0]      cnt, cnt_next, p_cnt;
  logic [7:0]      mt, mt_next, p_mt;
  logic [27:0]     skip, skip_next, p_skip;
  logic [23:0]     cap, cap_next, p_cap;
  logic [2:0]      seen, seen_next, p_seen;
  logic            fin, fin_next, p_fin;

  logic [7:0]  b;
  logic [27:0] acc_v;
  logic [2:0]  cnt_v;
  logic        vdone, vlong;
  logic [TICK_BITS_W:0] sum_t;
  logic        data1_path, chan_do, meta_do;
  logic [6:0]  cd1, cd2;
  logic [3:0]  ch, hi;
  logic [27:0] mlen, pos, skip_dec;
  logic [23:0] mcap, capv;
  logic        f5, mv, mal2;
  mtep_pkg::result_t mres;
  mtep_pkg::note_act_t p_act;
  logic        parsing;

  assign b        = item.data_byte;
  assign acc_v    = {acc[20:0], b[6:0]};
  assign cnt_v    = cnt + 3'd1;
  assign vdone    = !b[7];
  assign vlong    = b[7] && (cnt_v >= 3'd4);
  assign sum_t    = {1'b0, tick} + {{(TICK_BITS_W-27){1'b0}}, acc_v};
  assign ch       = rs[3:0];
  assign hi       = rs[7:4];
  assign pos      = acc - skip;
  assign skip_dec = skip - 28'd1;

  always_comb begin
    p_phase = phase; p_tick = tick; p_rs = rs; p_acc = acc; p_cnt = cnt;
    p_mt = mt; p_skip = skip; p_cap = cap; p_seen = seen; p_fin = fin;
    data1_path = 1'b0; chan_do = 1'b0; meta_do = 1'b0;
    cd1 = '0; cd2 = '0; mlen = '0; mcap = '0; capv = cap;
    f5 = 1'b0; mv = 1'b0; mal2 = 1'b0; mres = '0; p_act = mtep_pkg::NA_NONE;
    unique case (phase)
      PH_STATUS: begin
        p_acc = '0;
        p_cnt = '0;
        if (b == 8'hFF) begin
          p_phase = PH_META_TYPE;
        end else if (b == 8'hF0 || b == 8'hF7) begin
          p_phase = PH_SYSEX_LEN;
        end else if (b[7]) begin
          if (b >= 8'hF0) begin
            mv = 1'b1; mres.event_kind = mtep_pkg::K_MALFORMED; p_fin = 1'b1;
          end else begin
            p_rs = b;
            p_phase = PH_DATA1;
          end
        end else if (rs == 8'h00) begin
          mv = 1'b1; mres.event_kind = mtep_pkg::K_MALFORMED; p_fin = 1'b1;
        end else begin
          data1_path = 1'b1;
        end
      end
      PH_DATA1: begin
        data1_path = 1'b1;
      end
      PH_DATA2: begin
        chan_do = 1'b1;
        cd1 = cap[6:0];
        cd2 = b[6:0];
      end
      PH_META_TYPE: begin
        p_mt = b;
        p_phase = PH_META_LEN;
      end
      PH_META_LEN: begin
        p_acc = acc_v;
        p_cnt = cnt_v;
        if (vlong) begin
          mv = 1'b1; mres.event_kind = mtep_pkg::K_MALFORMED; p_fin = 1'b1;
        end else if (vdone) begin
          p_rs = '0;
          p_cap = '0;
          if (acc_v == '0) begin
            meta_do = 1'b1;
          end else begin
            p_skip = acc_v;
            p_phase = PH_META_DATA;
          end
        end
      end
      PH_META_DATA: begin
        case (pos)
          28'd0:   capv = cap | {b, 16'h0000};
          28'd1:   capv = cap | {8'h00, b, 8'h00};
          28'd2:   capv = cap | {16'h0000, b};
          default: capv = cap;
        endcase
        p_cap = capv;
        p_skip = skip_dec;
        if (skip_dec == '0) begin
          meta_do = 1'b1;
          mlen = acc;
          mcap = capv;
        end
      end
      PH_SYSEX_LEN: begin
        p_acc = acc_v;
        p_cnt = cnt_v;
        if (vlong) begin
          mv = 1'b1; mres.event_kind = mtep_pkg::K_MALFORMED; p_fin = 1'b1;
        end else if (vdone) begin
          p_rs = '0;
          p_skip = acc_v;
          p_acc = '0;
          p_cnt = '0;
          p_phase = (acc_v == '0) ? PH_DELTA : PH_SKIP;
        end
      end
      PH_SKIP: begin
        p_skip = skip_dec;
        if (skip_dec == '0) begin
          p_phase = PH_DELTA;
        end
      end
      default: begin
        p_acc = acc_v;
        p_cnt = cnt_v;
        p_phase = PH_DELTA;
        if (vlong) begin
          mv = 1'b1; mres.event_kind = mtep_pkg::K_MALFORMED; p_fin = 1'b1;
        end else if (vdone) begin
          p_tick = sum_t[TICK_BITS_W] ? '1 : sum_t[TICK_BITS_W-1:0];
          p_acc = '0;
          p_cnt = '0;
          p_phase = PH_STATUS;
        end
      end
    endcase

    if (data1_path) begin
      if (hi == 4'hC || hi == 4'hD) begin
        chan_do = 1'b1;
        cd1 = b[6:0];
        cd2 = '0;
      end else begin
        p_cap = {17'h00000, b[6:0]};
        p_phase = PH_DATA2;
      end
    end

    if (chan_do) begin
      p_phase = PH_DELTA;
      if (!seen[0]) begin
        p_seen[0] = 1'b1;
        f5 = 1'b1;
      end
      case (hi)
        4'h9: p_act = (cd2 != '0) ? mtep_pkg::NA_ON : mtep_pkg::NA_OFF;
        4'h8: p_act = mtep_pkg::NA_OFF;
        4'hB: begin
          mv = 1'b1; mres = mtep_pkg::mk_simple(mtep_pkg::K_CC, ch, cd1, {7'h00, cd2}, '0);
        end
        4'hE: begin
          mv = 1'b1; mres = mtep_pkg::mk_simple(mtep_pkg::K_BEND, ch, '0, {cd2, cd1}, '0);
        end
        4'hD: begin
          mv = 1'b1;
          mres = mtep_pkg::mk_simple(mtep_pkg::K_PRESSURE, ch, '0, {7'h00, cd1}, '0);
        end
        4'hC: begin
          if (!seen[1]) begin
            p_seen[1] = 1'b1;
            mv = 1'b1;
            mres = mtep_pkg::mk_simple(mtep_pkg::K_PROGRAM, ch, '0, {7'h00, cd1}, '0);
          end
        end
        default: p_act = mtep_pkg::NA_NONE;
      endcase
    end

    if (meta_do) begin
      p_acc = '0;
      p_cnt = '0;
      p_phase = PH_DELTA;
      case (mt)
        8'h2F: begin
          p_fin = 1'b1;
          mv = 1'b1; mres.event_kind = mtep_pkg::K_END;
        end
        8'h51: begin
          if (mlen >= 28'd3 && mcap != '0) begin
            mv = 1'b1; mres.event_kind = mtep_pkg::K_TEMPO; mres.tempo_us = mcap;
          end
        end
        8'h58: begin
          if (mlen >= 28'd2 && mcap[23:16] != 8'h00 && mcap[15:8] <= 8'd7) begin
            mv = 1'b1;
            mres.event_kind = mtep_pkg::K_TIMESIG;
            mres.value = {6'h00, mcap[23:16]};
            mres.den_log2 = mcap[10:8];
          end
        end
        8'h20: begin
          if (!seen[2] && mlen >= 28'd1) begin
            p_seen[2] = 1'b1;
            mv = 1'b1; mres.event_kind = mtep_pkg::K_PREFIX; mres.channel = mcap[19:16];
          end
        end
        default: mv = 1'b0;
      endcase
    end

    if (!p_fin && item.last_byte) begin
      if (p_phase != PH_DELTA) begin
        mal2 = 1'b1;
      end
      p_fin = 1'b1;
    end
    mres.tick = p_tick;
  end

  assign parsing = (item.operation == mtep_pkg::OP_BYTE) && !fin;

  always_comb begin
    phase_next = phase; tick_next = tick; rs_next = rs; acc_next = acc; cnt_next = cnt;
    mt_next = mt; skip_next = skip; cap_next = cap; seen_next = seen; fin_next = fin;
    if (accept && item.operation == mtep_pkg::OP_NEW) begin
      phase_next = PH_DELTA; tick_next = '0; rs_next = '0; acc_next = '0; cnt_next = '0;
      mt_next = '0; skip_next = '0; cap_next = '0; seen_next = '0; fin_next = 1'b0;
    end else if (accept && parsing) begin
      phase_next = p_phase; tick_next = p_tick; rs_next = p_rs; acc_next = p_acc;
      cnt_next = p_cnt; mt_next = p_mt; skip_next = p_skip; cap_next = p_cap;
      seen_next = p_seen; fin_next = p_fin;
    end
  end

  always_comb begin
    stage       = '0;
    stage.drain = (item.operation == mtep_pkg::OP_DRAIN);
    stage.clear = (item.operation == mtep_pkg::OP_NEW);
    stage.tick  = tick;
    if (parsing) begin
      stage.tick = p_tick;
      stage.act  = p_act;
      stage.idx  = {ch, cd1};
      stage.vel  = cd2;
      if (f5) begin
        stage.res[stage.nres[0]] =
          mtep_pkg::mk_simple(mtep_pkg::K_FIRST_CH, ch, '0, '0, p_tick);
        stage.nres = stage.nres + 2'd1;
      end
      if (mv) begin
        stage.res[stage.nres[0]] = mres;
        stage.nres = stage.nres + 2'd1;
      end
      if (mal2) begin
        stage.res[stage.nres[0]] =
          mtep_pkg::mk_simple(mtep_pkg::K_MALFORMED, '0, '0, '0, p_tick);
        stage.nres = stage.nres + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DELTA; tick <= '0; rs <= '0; acc <= '0; cnt <= '0;
      mt <= '0; skip <= '0; cap <= '0; seen <= '0; fin <= 1'b0;
    end else begin
      phase <= phase_next; tick <= tick_next; rs <= rs_next; acc <= acc_next;
      cnt <= cnt_next; mt <= mt_next; skip <= skip_next; cap <= cap_next;
      seen <= seen_next; fin <= fin_next;
    end
  end

endmodule

// ===== hdl/mtep_notes.sv =====
// Open-note table stage: row bitmap and note info memories, drain search.
module mtep_notes (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  mtep_pkg::stage_t  stage_in,
  input  logic              room,
  input  logic [14:0]       ticks_per_quarter,
  output logic              in_ready,
  output mtep_pkg::push_t   push
);

  typedef enum logic [2:0] {
    DP_FIND  = 3'b001,
    DP_ROW   = 3'b010,
    DP_READY = 3'b100
  } dphase_t;

  localparam int RB = mtep_pkg::ROW_BITS;
  localparam int CB = mtep_pkg::COL_BITS;
  localparam int SB = mtep_pkg::SLOT_BITS;

  mtep_pkg::stage_t s1;
  logic             s1_valid;
  dphase_t          dph;
  logic [mtep_pkg::ROWS-1:0] summary;

  logic                      fwr_v, fwi_v;
  logic [RB-1:0]             fwr_row;
  logic [mtep_pkg::COLS-1:0] fwr_data;
  logic [SB-1:0]             fwi_idx;
  logic [mtep_pkg::INFO_W-1:0] fwi_data;
  logic [SB-1:0]             rr_idx;

  logic [SB-1:0]             rd_idx;
  logic [mtep_pkg::COLS-1:0] row_q, row_cur, row_new, bit_mask;
  logic [mtep_pkg::INFO_W-1:0] info_q, info_cur;
  logic [RB-1:0]             drow;
  logic [CB-1:0]             dcol;
  logic                      fire, bitv, closing, row_we, info_we;
  mtep_pkg::tick_t           st, len;
  logic [14:0]               tpq_m1;
  mtep_pkg::result_t         cres;

  assign fire     = s1_valid && dph == DP_READY && room;
  assign in_ready = !s1_valid || fire;

  always_comb begin
    drow = '0;
    for (int i = mtep_pkg::ROWS - 1; i >= 0; i--) begin
      if (summary[i]) begin
        drow = RB'(i);
      end
    end
  end

  assign row_cur = (fwr_v && fwr_row == rr_idx[SB-1:CB]) ? fwr_data :
                   (summary[rr_idx[SB-1:CB]] ? row_q : '0);
  assign info_cur = (fwi_v && fwi_idx == rr_idx) ? fwi_data : info_q;

  always_comb begin
    dcol = '0;
    for (int i = mtep_pkg::COLS - 1; i >= 0; i--) begin
      if (row_cur[i]) begin
        dcol = CB'(i);
      end
    end
  end

  always_comb begin
    if (s1_valid && dph == DP_FIND) begin
      rd_idx = {drow, {CB{1'b0}}};
    end else if (s1_valid && dph == DP_ROW) begin
      rd_idx = {rr_idx[SB-1:CB], dcol};
    end else if (accept) begin
      rd_idx = stage_in.idx;
    end else begin
      rd_idx = s1.idx;
    end
  end

  assign bit_mask = mtep_pkg::COLS'(1) << s1.idx[CB-1:0];
  assign bitv     = |(row_cur & bit_mask);
  assign closing  = s1.act != mtep_pkg::NA_NONE && bitv;
  assign row_new  = (s1.act == mtep_pkg::NA_ON) ? (row_cur | bit_mask) : (row_cur & ~bit_mask);
  assign row_we   = fire && s1.act != mtep_pkg::NA_NONE;
  assign info_we  = fire && s1.act == mtep_pkg::NA_ON;

  assign st     = info_cur[mtep_pkg::INFO_W-1:7];
  assign len    = (s1.tick >= st) ? (s1.tick - st) : '0;
  assign tpq_m1 = ticks_per_quarter - 15'd1;

  always_comb begin
    cres              = '0;
    cres.event_kind   = mtep_pkg::K_NOTE;
    cres.channel      = s1.idx[SB-1:7];
    cres.key          = s1.idx[6:0];
    cres.value        = {7'h00, info_cur[6:0]};
    cres.tick         = st;
    cres.length_ticks = len;
    cres.short_note   = (ticks_per_quarter != '0) && (len <= mtep_pkg::tick_t'(tpq_m1[14:7]));
    cres.last         = 1'b1;
  end

  always_comb begin
    push = '0;
    if (fire) begin
      push.res = s1.res;
      push.n   = s1.nres;
      if (closing) begin
        push.res[s1.nres[0]] = cres;
        push.n = s1.nres + 2'd1;
      end else if (s1.nres != '0) begin
        push.res[s1.nres[1]].last = 1'b1;
      end
    end
  end

  mtep_ram #(.WIDTH(mtep_pkg::COLS), .DEPTH(mtep_pkg::ROWS)) u_rows (
    .clk   (clk),
    .we    (row_we),
    .waddr (s1.idx[SB-1:CB]),
    .wdata (row_new),
    .raddr (rd_idx[SB-1:CB]),
    .rdata (row_q)
  );

  mtep_ram #(.WIDTH(mtep_pkg::INFO_W), .DEPTH(mtep_pkg::SLOTS)) u_info (
    .clk   (clk),
    .we    (info_we),
    .waddr (s1.idx),
    .wdata ({s1.tick, s1.vel}),
    .raddr (rd_idx),
    .rdata (info_q)
  );

  always_ff @(posedge clk) begin
    rr_idx   <= rd_idx;
    fwr_row  <= s1.idx[SB-1:CB];
    fwr_data <= row_new;
    fwi_idx  <= s1.idx;
    fwi_data <= {s1.tick, s1.vel};
    if (rst) begin
      s1_valid <= 1'b0;
      dph      <= DP_READY;
      summary  <= '0;
      fwr_v    <= 1'b0;
      fwi_v    <= 1'b0;
      s1       <= '0;
    end else begin
      fwr_v <= row_we;
      fwi_v <= info_we;
      if (fire) begin
        if (s1.clear) begin
          summary <= '0;
        end else if (row_we) begin
          summary[s1.idx[SB-1:CB]] <= |row_new;
        end
      end
      if (accept) begin
        s1       <= stage_in;
        s1_valid <= 1'b1;
        dph      <= stage_in.drain ? DP_FIND : DP_READY;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end else if (s1_valid) begin
        unique case (dph)
          DP_FIND: begin
            if (summary == '0) begin
              s1.res[0] <= mtep_pkg::mk_simple(mtep_pkg::K_DRAIN_END, '0, '0, '0, s1.tick);
              s1.nres   <= 2'd1;
              dph       <= DP_READY;
            end else begin
              dph <= DP_ROW;
            end
          end
          DP_ROW: begin
            s1.idx <= {rr_idx[SB-1:CB], dcol};
            s1.act <= mtep_pkg::NA_OFF;
            dph    <= DP_READY;
          end
          default: dph <= dph;
        endcase
      end
    end
  end

  a_find_leaves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && dph == DP_FIND |=> s1_valid && (dph == DP_ROW || dph == DP_READY))
    else $error("drain search did not leave its first step");

  a_row_nonempty: assert property (@(posedge clk) disable iff (rst)
    s1_valid && dph == DP_ROW |-> row_cur != '0)
    else $error("drain picked a row with no open note");

  a_row_closes: assert property (@(posedge clk) disable iff (rst)
    s1_valid && dph == DP_ROW |=> s1.act == mtep_pkg::NA_OFF && dph == DP_READY)
    else $error("drain did not set up a close");

  a_drain_closes: assert property (@(posedge clk) disable iff (rst)
    s1_valid && dph == DP_ROW |=> bitv)
    else $error("drained slot not open when read back");

endmodule

// ===== hdl/mtep_outq.sv =====
// Four-entry result queue taking up to two items per cycle.
module mtep_outq (
  input  logic              clk,
  input  logic              rst,
  input  mtep_pkg::push_t   push,
  input  logic              result_ready,
  output logic              result_valid,
  output mtep_pkg::result_t result,
  output logic              room
);

  mtep_pkg::result_t q [4];
  logic [1:0] head, tail;
  logic [2:0] count;
  logic       pop;

  assign result_valid = count != '0;
  assign result       = q[head];
  assign pop          = result_valid && result_ready;
  assign room         = count <= 3'd2;

  always_ff @(posedge clk) begin
    if (push.n != '0) begin
      q[tail] <= push.res[0];
    end
    if (push.n == 2'd2) begin
      q[tail + 2'd1] <= push.res[1];
    end
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + {1'b0, pop};
      tail  <= tail + push.n;
      count <= count + {1'b0, push.n} - {2'b00, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.n != '0 |-> count <= 3'd2)
    else $error("result queue overflow");

endmodule

// ===== hdl/midi_track_event_parser.sv =====
// Top level of the MIDI track event parser.
//   channel   dir  handshake                       payload
//   item      in   item_valid / item_ready         item   (operation, data_byte, last_byte)
//   result    out  result_valid / result_ready     result (event_kind .. last)
//   cfg       in   cfg_valid / cfg_ready           cfg_data (ticks_per_quarter)
// One item enters per cycle while the table stage is free; a track byte is registered in
// the table stage and goes into the result queue when it fires; its first result can leave.
// A drain item holds the table stage through bitmap search, row read and info read. Results
// leave a four-entry queue at one per cycle while the sink is ready; the table stage stalls
// until two slots are free. Reset is synchronous and clears the open-note bitmap at once.
module midi_track_event_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  mtep_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output mtep_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [14:0]       cfg_data
);

  logic             accept, room;
  logic [14:0]      ticks_per_quarter;
  mtep_pkg::stage_t stage;
  mtep_pkg::push_t  push;

  assign accept    = item_valid && item_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_quarter <= 15'd96;
    end else if (cfg_valid && cfg_ready) begin
      ticks_per_quarter <= cfg_data;
    end
  end

  mtep_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .stage  (stage)
  );

  mtep_notes u_notes (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .stage_in          (stage),
    .room              (room),
    .ticks_per_quarter (ticks_per_quarter),
    .in_ready          (item_ready),
    .push              (push)
  );

  mtep_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result),
    .room         (room)
  );

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the MIDI track event parser: random and directed byte streams.
`timescale 1ns / 100ps

module tb_top;

  localparam int IDLE_MAX = 14;
  localparam int WATCHDOG = 20000;

  localparam int PH_DELTA = 0;
  localparam int PH_STATUS = 1;
  localparam int PH_META_TYPE = 2;
  localparam int PH_META_LEN = 3;
  localparam int PH_META_DATA = 4;
  localparam int PH_SYSEX_LEN = 5;
  localparam int PH_SKIP = 6;
  localparam int PH_DATA1 = 7;
  localparam int PH_DATA2 = 8;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [7:0] META_END = 8'h2F;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] META_TIMESIG = 8'h58;
  localparam logic [7:0] META_PREFIX = 8'h20;

  class event_scoreboard;
    logic [14:0] tpq;
    int phase;
    mtep_pkg::tick_t now;
    logic [7:0] run_status;
    logic [27:0] acc;
    int nbytes;
    logic [7:0] meta_type;
    logic [27:0] skip;
    logic [23:0] cap;
    logic [2:0] seen;
    bit finished;
    mtep_pkg::tick_t start_tick[mtep_pkg::SLOTS];
    logic [6:0] vel[mtep_pkg::SLOTS];
    bit open[mtep_pkg::SLOTS];
    mtep_pkg::result_t pending[$];
    mtep_pkg::result_t step_res[$];
    int errors;
    int checked;

    function new();
      errors = 0;
      checked = 0;
      tpq = 15'd96;
      clear_track();
    endfunction

    function void clear_track();
      phase = PH_DELTA;
      now = '0;
      run_status = '0;
      acc = '0;
      nbytes = 0;
      meta_type = '0;
      skip = '0;
      cap = '0;
      seen = '0;
      finished = 0;
      for (int i = 0; i < mtep_pkg::SLOTS; i++) begin
        open[i] = 0;
        start_tick[i] = '0;
        vel[i] = '0;
      end
    endfunction

    function void push(mtep_pkg::result_t r);
      if (step_res.size() < 2) step_res = {step_res, r};
    endfunction

    function void simple(logic [3:0] kind, logic [3:0] ch, logic [6:0] key, logic [13:0] val);
      mtep_pkg::result_t r;
      r = '0;
      r.event_kind = kind;
      r.channel = ch;
      r.key = key;
      r.value = val;
      r.tick = now;
      push(r);
    endfunction

    function void close_note(int idx);
      mtep_pkg::result_t r;
      mtep_pkg::tick_t len;
      len = (now >= start_tick[idx]) ? now - start_tick[idx] : '0;
      r = '0;
      r.event_kind = mtep_pkg::K_NOTE;
      r.channel = 4'(idx / 128);
      r.key = 7'(idx % 128);
      r.value = 14'(vel[idx]);
      r.tick = start_tick[idx];
      r.length_ticks = len;
      r.short_note = (tpq != 0 && len <= mtep_pkg::tick_t'((tpq - 15'd1) >> 7));
      open[idx] = 0;
      push(r);
    endfunction

    function void bad();
      finished = 1;
      simple(mtep_pkg::K_MALFORMED, '0, '0, '0);
    endfunction

    function int number_byte(logic [7:0] b);
      acc = {acc[20:0], b[6:0]};
      nbytes++;
      if (!b[7]) return 1;
      return (nbytes >= 4) ? 2 : 0;
    endfunction

    function void meta_done();
      mtep_pkg::result_t r;
      logic [27:0] mlen;
      logic [7:0] d0, d1;
      mlen = acc;
      d0 = cap[23:16];
      d1 = cap[15:8];
      acc = '0;
      nbytes = 0;
      phase = PH_DELTA;
      r = '0;
      r.tick = now;
      case (meta_type)
        META_END: begin
          finished = 1;
          simple(mtep_pkg::K_END, '0, '0, '0);
        end
        META_TEMPO: if (mlen >= 3 && cap != 0) begin
          r.event_kind = mtep_pkg::K_TEMPO;
          r.tempo_us = cap;
          push(r);
        end
        META_TIMESIG: if (mlen >= 2 && d0 > 0 && d1 <= 7) begin
          r.event_kind = mtep_pkg::K_TIMESIG;
          r.value = 14'(d0);
          r.den_log2 = d1[2:0];
          push(r);
        end
        META_PREFIX: if (!seen[2] && mlen >= 1) begin
          seen[2] = 1;
          simple(mtep_pkg::K_PREFIX, d0[3:0], '0, '0);
        end
        default: ;
      endcase
    endfunction

    function void chan_done(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
      logic [3:0] hi, ch;
      int idx;
      hi = st[7:4];
      ch = st[3:0];
      idx = ch * 128 + d1;
      phase = PH_DELTA;
      if (!seen[0]) begin
        seen[0] = 1;
        simple(mtep_pkg::K_FIRST_CH, ch, '0, '0);
      end
      if (hi == 4'h9 && d2 > 0) begin
        if (open[idx]) close_note(idx);
        start_tick[idx] = now;
        vel[idx] = d2;
        open[idx] = 1;
      end else if (hi == 4'h8 || hi == 4'h9) begin
        if (open[idx]) close_note(idx);
      end else if (hi == 4'hB) begin
        simple(mtep_pkg::K_CC, ch, d1, 14'(d2));
      end else if (hi == 4'hE) begin
        simple(mtep_pkg::K_BEND, ch, '0, {d2, d1});
      end else if (hi == 4'hD) begin
        simple(mtep_pkg::K_PRESSURE, ch, '0, 14'(d1));
      end else if (hi == 4'hC) begin
        if (!seen[1]) begin
          seen[1] = 1;
          simple(mtep_pkg::K_PROGRAM, ch, '0, 14'(d1));
        end
      end
    endfunction

    function void parse_byte(logic [7:0] b);
      int r;
      logic [27:0] pos;
      case (phase)
        PH_STATUS: begin
          acc = '0;
          nbytes = 0;
          if (b == 8'hFF) phase = PH_META_TYPE;
          else if (b == 8'hF0 || b == 8'hF7) phase = PH_SYSEX_LEN;
          else if (b[7]) begin
            if (b >= 8'hF0) bad();
            else begin
              run_status = b;
              phase = PH_DATA1;
            end
          end else begin
            if (run_status == 0) bad();
            else begin
              phase = PH_DATA1;
              parse_byte(b);
            end
          end
        end
        PH_DATA1: begin
          if (run_status[7:4] == 4'hC || run_status[7:4] == 4'hD)
            chan_done(run_status, b[6:0], '0);
          else begin
            cap = {17'd0, b[6:0]};
            phase = PH_DATA2;
          end
        end
        PH_DATA2: chan_done(run_status, cap[6:0], b[6:0]);
        PH_META_TYPE: begin
          meta_type = b;
          phase = PH_META_LEN;
        end
        PH_META_LEN: begin
          r = number_byte(b);
          if (r == 2) bad();
          else if (r == 1) begin
            run_status = '0;
            cap = '0;
            if (acc == 0) meta_done();
            else begin
              skip = acc;
              phase = PH_META_DATA;
            end
          end
        end
        PH_META_DATA: begin
          pos = acc - skip;
          if (pos < 3) cap = cap | (24'(b) << (16 - 8 * pos));
          skip = skip - 28'd1;
          if (skip == 0) meta_done();
        end
        PH_SYSEX_LEN: begin
          r = number_byte(b);
          if (r == 2) bad();
          else if (r == 1) begin
            run_status = '0;
            skip = acc;
            acc = '0;
            nbytes = 0;
            phase = (skip == 0) ? PH_DELTA : PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip = skip - 28'd1;
          if (skip == 0) phase = PH_DELTA;
        end
        default: begin
          r = number_byte(b);
          if (r == 2) bad();
          else if (r == 1) begin
            if (now > {mtep_pkg::TICK_BITS{1'b1}} - mtep_pkg::tick_t'(acc))
              now = {mtep_pkg::TICK_BITS{1'b1}};
            else now = now + mtep_pkg::tick_t'(acc);
            acc = '0;
            nbytes = 0;
            phase = PH_STATUS;
          end
        end
      endcase
    endfunction

    function void note_item(mtep_pkg::item_t it);
      int i;
      mtep_pkg::result_t r;
      step_res.delete();
      if (it.operation == mtep_pkg::OP_NEW) begin
        clear_track();
        return;
      end
      if (it.operation == mtep_pkg::OP_DRAIN) begin
        for (i = 0; i < mtep_pkg::SLOTS; i++) if (open[i]) break;
        if (i < mtep_pkg::SLOTS) close_note(i);
        else simple(mtep_pkg::K_DRAIN_END, '0, '0, '0);
      end else if (it.operation == mtep_pkg::OP_BYTE) begin
        if (finished) return;
        parse_byte(it.data_byte);
        if (!finished && it.last_byte) begin
          if (phase != PH_DELTA) bad();
          finished = 1;
        end
      end
      for (i = 0; i < step_res.size(); i++) begin
        r = step_res[i];
        r.last = (i == step_res.size() - 1);
        pending = {pending, r};
      end
    endfunction

    function void check_result(mtep_pkg::result_t got);
      mtep_pkg::result_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) $display("mismatch\n  expected %p\n  actual   %p", exp_r, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_ready;
  mtep_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 0;
  mtep_pkg::result_t result;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [14:0] cfg_data = '0;

  event_scoreboard sb;
  int idle_cycles;
  int sent;
  bit sink_calm;
  bit stim_done;

  midi_track_event_parser dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) sb.note_item(item);
      if (result_valid && result_ready) sb.check_result(result);
      if ((item_valid && item_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // The sink waits a random number of cycles before taking each result, unless sink_calm is set.
  initial begin
    int gap;
    forever begin
      gap = sink_calm ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap > 0) begin
        result_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      result_ready <= 1;
      @(posedge clk);
      while (result_valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send(logic [1:0] op, logic [7:0] b, logic lastb, bit calm = 0);
    int gap;
    gap = calm ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      item_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    item.operation <= op;
    item.data_byte <= b;
    item.last_byte <= lastb;
    item_valid <= 1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic release_item();
    item_valid <= 0;
  endtask

  task automatic settle();
    release_item();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_tpq(logic [14:0] v);
    cfg_data <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.tpq = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic byte_out(logic [7:0] b, bit calm);
    send(mtep_pkg::OP_BYTE, b, 0, calm);
  endtask

  task automatic delta(int d, bit calm);
    if (d >= (1 << 21)) byte_out(8'h80 | 8'((d >> 21) & 127), calm);
    if (d >= (1 << 14)) byte_out(8'h80 | 8'((d >> 14) & 127), calm);
    if (d >= (1 << 7)) byte_out(8'h80 | 8'((d >> 7) & 127), calm);
    byte_out(8'(d & 127), calm);
  endtask

  // One random event, mostly well formed, preceded by its delta time.
  task automatic random_event(bit calm);
    int sel, n, d;
    logic [7:0] st;
    sel = $urandom_range(0, 99);
    d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32'h0FFFFFFF) : $urandom_range(0, 200);
    delta(d, calm);
    if (sel < 45) begin
      st = ($urandom_range(0, 1) ? 8'h90 : 8'h80) | 8'($urandom_range(0, 3));
      if ($urandom_range(0, 3) != 0) byte_out(st, calm);
      else if (sb.run_status == 0) byte_out(st, calm);
      byte_out(8'($urandom_range(60, 67)) | ($urandom_range(0, 7) == 0 ? 8'h80 : 8'h00), calm);
      byte_out($urandom_range(0, 4) == 0 ? 8'h00 : 8'($urandom_range(0, 255)), calm);
    end else if (sel < 70) begin
      st = 8'($urandom_range(8, 14) << 4) | 8'($urandom_range(0, 15));
      byte_out(st, calm);
      byte_out(8'($urandom_range(0, 255)), calm);
      if (st[7:4] != 4'hC && st[7:4] != 4'hD) byte_out(8'($urandom_range(0, 255)), calm);
    end else if (sel < 90) begin
      byte_out(8'hFF, calm);
      case ($urandom_range(0, 4))
        0: byte_out(META_TEMPO, calm);
        1: byte_out(META_TIMESIG, calm);
        2: byte_out(META_PREFIX, calm);
        3: byte_out(8'h03, calm);
        default: byte_out(8'($urandom_range(0, 255)), calm);
      endcase
      n = $urandom_range(0, 5);
      byte_out(8'(n), calm);
      repeat (n) byte_out(8'($urandom_range(0, 255)), calm);
    end else if (sel < 96) begin
      byte_out($urandom_range(0, 1) ? 8'hF0 : 8'hF7, calm);
      n = $urandom_range(0, 4);
      byte_out(8'(n), calm);
      repeat (n) byte_out(8'($urandom_range(0, 255)), calm);
    end else begin
      byte_out(8'($urandom_range(0, 255)), calm);
    end
  endtask

  initial begin
    int tracks, r;
    sb = new();
    sent = 0;
    idle_cycles = 0;
    sink_calm = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed part: extremes, metas, malformed cases and drains.
    write_tpq(15'd32767);
    byte_out(8'h00, 1); byte_out(8'h45, 1);
    byte_out(8'h00, 1); byte_out(8'h9F, 1); byte_out(8'h7F, 1); byte_out(8'h7F, 1);
    byte_out(8'h81, 1); byte_out(8'h00, 1); byte_out(8'hFF, 1); byte_out(8'h7F, 1);
    byte_out(8'h00, 1);
    byte_out(8'hFF, 1); byte_out(8'hFF, 1); byte_out(8'hFF, 1); byte_out(8'hFF, 1);
    send(mtep_pkg::OP_DRAIN, 8'h00, 1, 1);
    send(mtep_pkg::OP_DRAIN, 8'hFF, 0, 1);
    send(OP_UNUSED, 8'hAA, 1, 1);
    send(mtep_pkg::OP_NEW, 8'h55, 0, 1);
    byte_out(8'h00, 1); byte_out(8'hF3, 1);
    send(mtep_pkg::OP_NEW, 8'h00, 0, 1);
    byte_out(8'h00, 1); byte_out(8'hFF, 1); byte_out(META_END, 1); byte_out(8'h00, 1);
    send(mtep_pkg::OP_BYTE, 8'h90, 1, 1);
    settle();
    write_tpq(15'd1);
    sb.clear_track();
    send(mtep_pkg::OP_NEW, 8'h00, 0, 1);
    byte_out(8'h00, 1); send(mtep_pkg::OP_BYTE, 8'h90, 1, 1);
    settle();

    // Random tracks with random configuration between them.
    tracks = 0;
    while (sent < 1800) begin
      r = $urandom_range(0, 3);
      sink_calm = ($urandom_range(0, 4) == 0);
      if (tracks % 6 == 0) begin
        settle();
        write_tpq(r == 0 ? 15'd1 : (r == 1 ? 15'd32767 : 15'($urandom_range(1, 32767))));
      end
      send(mtep_pkg::OP_NEW, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sink_calm);
      repeat ($urandom_range(3, 25)) begin
        random_event(sink_calm);
        if ($urandom_range(0, 15) == 0)
          send(mtep_pkg::OP_DRAIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               sink_calm);
      end
      if ($urandom_range(0, 2) == 0) begin
        byte_out(8'h00, sink_calm);
        byte_out(8'hFF, sink_calm);
        byte_out(META_END, sink_calm);
        byte_out(8'h00, sink_calm);
      end
      send(mtep_pkg::OP_BYTE, 8'($urandom_range(0, 255)), 1, sink_calm);
      repeat ($urandom_range(1, 6))
        send(mtep_pkg::OP_DRAIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
             sink_calm);
      tracks++;
    end
    sink_calm = 0;
    settle();
    $display("Covered %0d items over %0d random tracks; %0d results checked.",
             sent, tracks, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results still expected", sb.errors, sb.pending.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== midi_track_event_parser.f =====
hdl/mtep_pkg.sv
hdl/mtep_ram.sv
hdl/mtep_parser.sv
hdl/mtep_notes.sv
hdl/mtep_outq.sv
hdl/midi_track_event_parser.sv
tb/tb_top.sv
